// ----- design/station_route_planner_defines.svh -----
// Assertion macros shared by the station route planner checker.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef STATION_ROUTE_PLANNER_DEFINES_SVH
`define STATION_ROUTE_PLANNER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("station_route_planner check failed");

// Consequent must hold in the cycle after the antecedent.
`define SRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("station_route_planner check failed");

`endif

// ----- design/srp_pkg.sv -----
// Shared types and constants of the station route planner.
// Used by the controller, the datapath and the checker.
package srp_pkg;

    // Fixed widths of the item fields.
    localparam int NODE_BITS = 3;
    localparam int OP_BITS   = 2;

    // Opcodes of an input item.
    localparam logic [OP_BITS-1:0] OP_EDGE = 2'd0;
    localparam logic [OP_BITS-1:0] OP_POS  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_PLAN = 2'd2;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_NEAR_SQ,
        S_NEAR_CMP,
        S_NEAR_DONE,
        S_INIT,
        S_SEL,
        S_SETTLE,
        S_RLX_RD,
        S_RLX_UPD,
        S_CHECK,
        S_TRACE,
        S_EMIT,
        S_EMIT_START,
        S_EMIT_UNR
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic near_sq;
        logic near_cmp;
        logic init;
        logic sel_step;
        logic settle;
        logic rlx_rd;
        logic rlx_upd;
        logic sel_goal;
        logic trace_init;
        logic trace_step;
        logic emit_trail;
        logic emit_start;
        logic out_unr;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic plan_in;
        logic j_last;
        logic found;
        logic goal_is_start;
        logic goal_bad;
        logic trace_end;
        logic emit_last;
        logic out_free;
    } sts_t;

endpackage

// ----- design/station_route_planner.sv -----
// Station route planner top level: controller plus datapath.
// Depends on srp_pkg, srp_ctrl and srp_dp.
//
// Edge and position writes are taken one per cycle while idle and give no
// item. A plan item finds the nearest station (squared distance, then a
// compare for each station), then, unless the goal is that station, runs
// Dijkstra with one shared scan counter: each settled node takes a minimum
// search over all nodes, a settle step and a relaxation of every node
// through the registered edge-memory read port. The route is then walked
// back one station per cycle and sent one station per cycle while the output
// side does not stall. One item is worked at a time; the last route item
// sits in the output register while the next item is taken.
module station_route_planner #(
    parameter int NODES       = 8,
    parameter int WEIGHT_BITS = 16,
    parameter int COORD_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [srp_pkg::OP_BITS-1:0]    opcode,
    input  logic [srp_pkg::NODE_BITS-1:0]  node_a,
    input  logic [srp_pkg::NODE_BITS-1:0]  node_b,
    input  logic [15:0]                    weight,
    input  logic signed [15:0]             pos_x,
    input  logic signed [15:0]             pos_y,
    input  logic [srp_pkg::NODE_BITS-1:0]  goal_node,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [srp_pkg::NODE_BITS-1:0]  route_node,
    output logic                           last_in_route,
    output logic                           unreachable
);

    srp_pkg::cmd_t cmd;
    srp_pkg::sts_t sts;

    // Sequencer.
    srp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // Tables and arithmetic.
    srp_dp #(
        .NODES       (NODES),
        .WEIGHT_BITS (WEIGHT_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .opcode        (opcode),
        .node_a        (node_a),
        .node_b        (node_b),
        .weight        (weight),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .goal_node     (goal_node),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .route_node    (route_node),
        .last_in_route (last_in_route),
        .unreachable   (unreachable)
    );

endmodule

// ----- design/srp_ctrl.sv -----
// Sequencing state machine of the station route planner.
// Depends on srp_pkg; drives the datapath through srp_pkg::cmd_t.
module srp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  srp_pkg::sts_t  sts,
    output srp_pkg::cmd_t  cmd,
    output logic           in_stall
);

    srp_pkg::state_t state_reg;
    srp_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            srp_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
                if (in_valid && sts.plan_in)
                begin
                    state_next = srp_pkg::S_NEAR_SQ;
                end
            end
            srp_pkg::S_NEAR_SQ:
            begin
                cmd.near_sq = 1'b1;
                state_next  = srp_pkg::S_NEAR_CMP;
            end
            srp_pkg::S_NEAR_CMP:
            begin
                cmd.near_cmp = 1'b1;
                state_next   = sts.j_last ? srp_pkg::S_NEAR_DONE : srp_pkg::S_NEAR_SQ;
            end
            srp_pkg::S_NEAR_DONE:
            begin
                state_next = sts.goal_is_start ? srp_pkg::S_EMIT_START : srp_pkg::S_INIT;
            end
            srp_pkg::S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = srp_pkg::S_SEL;
            end
            srp_pkg::S_SEL:
            begin
                cmd.sel_step = 1'b1;
                if (sts.j_last)
                begin
                    state_next = srp_pkg::S_SETTLE;
                end
            end
            srp_pkg::S_SETTLE:
            begin
                if (sts.found)
                begin
                    cmd.settle = 1'b1;
                    state_next = srp_pkg::S_RLX_RD;
                end
                else
                begin
                    state_next = srp_pkg::S_CHECK;
                end
            end
            srp_pkg::S_RLX_RD:
            begin
                cmd.rlx_rd = 1'b1;
                state_next = srp_pkg::S_RLX_UPD;
            end
            srp_pkg::S_RLX_UPD:
            begin
                cmd.rlx_upd = 1'b1;
                state_next  = sts.j_last ? srp_pkg::S_SEL : srp_pkg::S_RLX_RD;
            end
            srp_pkg::S_CHECK:
            begin
                cmd.sel_goal = 1'b1;
                if (sts.goal_bad)
                begin
                    state_next = srp_pkg::S_EMIT_UNR;
                end
                else
                begin
                    cmd.trace_init = 1'b1;
                    state_next     = srp_pkg::S_TRACE;
                end
            end
            srp_pkg::S_TRACE:
            begin
                cmd.trace_step = 1'b1;
                if (sts.trace_end)
                begin
                    state_next = srp_pkg::S_EMIT;
                end
            end
            srp_pkg::S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_trail = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = srp_pkg::S_IDLE;
                    end
                end
            end
            srp_pkg::S_EMIT_START:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = srp_pkg::S_IDLE;
                end
            end
            srp_pkg::S_EMIT_UNR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_start = 1'b1;
                    cmd.out_unr    = 1'b1;
                    state_next     = srp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = srp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/srp_dp.sv -----
// Datapath of the station route planner: tables, nearest-station scan,
// shortest-path registers, route trail and output register. Depends on srp_pkg.
module srp_dp #(
    parameter int NODES       = 8,
    parameter int WEIGHT_BITS = 16,
    parameter int COORD_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  srp_pkg::cmd_t                     cmd,
    output srp_pkg::sts_t                     sts,
    input  logic [srp_pkg::OP_BITS-1:0]       opcode,
    input  logic [srp_pkg::NODE_BITS-1:0]     node_a,
    input  logic [srp_pkg::NODE_BITS-1:0]     node_b,
    input  logic [15:0]                       weight,
    input  logic signed [15:0]                pos_x,
    input  logic signed [15:0]                pos_y,
    input  logic [srp_pkg::NODE_BITS-1:0]     goal_node,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [srp_pkg::NODE_BITS-1:0]     route_node,
    output logic                              last_in_route,
    output logic                              unreachable
);

    localparam int IW  = $clog2(NODES);
    localparam int CW  = COORD_BITS;
    localparam int DW  = WEIGHT_BITS + 4;
    localparam int NE  = NODES * NODES;
    localparam int AW  = $clog2(NE);
    localparam int SQW = 2 * CW + 2;
    localparam int SSW = SQW + 1;
    localparam int NB  = srp_pkg::NODE_BITS;
    localparam logic [DW-1:0] INF = {DW{1'b1}};
    localparam logic [DW-1:0] SAT = INF - DW'(1);

    // Tables.
    logic [WEIGHT_BITS-1:0]  edge_mem_reg [NE];
    logic [NE-1:0]           edge_vld_reg;
    logic signed [CW-1:0]    px_reg [NODES];
    logic signed [CW-1:0]    py_reg [NODES];

    // Query and scan registers.
    logic signed [CW-1:0]    qx_reg;
    logic signed [CW-1:0]    qy_reg;
    logic [NB-1:0]           goal_reg;
    logic [IW-1:0]           j_reg;
    logic [IW-1:0]           start_reg;
    logic [SSW-1:0]          bsq_reg;
    logic [SQW-1:0]          sqx_reg;
    logic [SQW-1:0]          sqy_reg;

    // Shortest-path state.
    logic [DW-1:0]           dist_reg [NODES];
    logic [NODES-1:0]        vis_reg;
    logic [IW-1:0]           pred_reg [NODES];
    logic                    found_reg;
    logic [DW-1:0]           min_reg;
    logic [IW-1:0]           u_reg;
    logic [DW-1:0]           udist_reg;
    logic [WEIGHT_BITS-1:0]  rd_w_reg;
    logic                    rd_v_reg;

    // Route trail and output.
    logic [IW-1:0]           trail_reg [NODES];
    logic [IW-1:0]           v_reg;
    logic [IW-1:0]           n_reg;
    logic [IW-1:0]           e_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [NB-1:0]           node_out_reg;
    logic                    last_reg;
    logic                    unr_reg;

    // Input conversions.
    logic signed [CW+15:0]   wide_x;
    logic signed [CW+15:0]   wide_y;
    logic [WEIGHT_BITS+15:0] wide_w;
    logic [IW+NB-1:0]        a_ext;
    logic [IW+NB-1:0]        b_ext;
    logic [IW+NB-1:0]        g_ext;
    logic [IW-1:0]           a_idx;
    logic [IW-1:0]           b_idx;
    logic [IW-1:0]           g_idx;
    logic                    a_ok;
    logic                    b_ok;
    logic                    g_ok;
    logic [AW-1:0]           wr_addr;
    logic [AW-1:0]           rd_addr;

    // Combinational datapath values.
    logic signed [CW:0]      dx;
    logic signed [CW:0]      dy;
    logic [CW:0]             mx;
    logic [CW:0]             my;
    logic [SSW-1:0]          sq_sum;
    logic [IW-1:0]           d_addr;
    logic [DW-1:0]           d_rd;
    logic [WEIGHT_BITS-1:0]  w_eff;
    logic [DW:0]             sum;
    logic [DW-1:0]           sum_sat;
    logic                    j_last;
    logic                    trace_end;
    logic [IW+NB-1:0]        trail_ext;
    logic [IW+NB-1:0]        start_ext;

    assign wide_x = {{CW{pos_x[15]}}, pos_x};
    assign wide_y = {{CW{pos_y[15]}}, pos_y};
    assign wide_w = {{WEIGHT_BITS{1'b0}}, weight};
    assign a_ext  = {{IW{1'b0}}, node_a};
    assign b_ext  = {{IW{1'b0}}, node_b};
    assign g_ext  = {{IW{1'b0}}, goal_reg};
    assign a_idx  = a_ext[IW-1:0];
    assign b_idx  = b_ext[IW-1:0];
    assign g_idx  = g_ext[IW-1:0];
    assign a_ok   = 32'(node_a) < NODES;
    assign b_ok   = 32'(node_b) < NODES;
    assign g_ok   = 32'(goal_reg) < NODES;
    assign wr_addr = AW'(a_idx) * AW'(NODES) + AW'(b_idx);
    assign rd_addr = AW'(u_reg) * AW'(NODES) + AW'(j_reg);

    // Distance from the query point to the station under scan.
    assign dx     = {qx_reg[CW-1], qx_reg} - {px_reg[j_reg][CW-1], px_reg[j_reg]};
    assign dy     = {qy_reg[CW-1], qy_reg} - {py_reg[j_reg][CW-1], py_reg[j_reg]};
    assign mx     = dx[CW] ? $unsigned(-dx) : $unsigned(dx);
    assign my     = dy[CW] ? $unsigned(-dy) : $unsigned(dy);
    assign sq_sum = SSW'(sqx_reg) + SSW'(sqy_reg);

    // One read port on the distance registers, shared by selection, relaxation and goal check.
    assign d_addr = cmd.sel_goal ? g_idx : j_reg;
    assign d_rd   = dist_reg[d_addr];

    // Relaxation sum, saturated one below infinite.
    assign w_eff   = rd_v_reg ? rd_w_reg : '0;
    assign sum     = {1'b0, udist_reg} + (DW+1)'(w_eff);
    assign sum_sat = (sum > (DW+1)'(SAT)) ? SAT : sum[DW-1:0];

    assign j_last    = j_reg == IW'(NODES - 1);
    assign trace_end = (v_reg == start_reg) || (n_reg == IW'(NODES - 1));
    assign trail_ext = {{NB{1'b0}}, trail_reg[e_reg]};
    assign start_ext = {{NB{1'b0}}, start_reg};

    always_comb
    begin
        sts.plan_in       = opcode == srp_pkg::OP_PLAN;
        sts.j_last        = j_last;
        sts.found         = found_reg;
        sts.goal_is_start = g_ok && (g_idx == start_reg);
        sts.goal_bad      = !g_ok || (d_rd == INF);
        sts.trace_end     = trace_end;
        sts.emit_last     = e_reg == '0;
        sts.out_free      = !out_valid_reg || !out_stall;
    end

    // Edge weight memory; an entry never written reads as no edge.
    always_ff @(posedge clk)
    begin
        if (cmd.take && opcode == srp_pkg::OP_EDGE && a_ok && b_ok)
        begin
            edge_mem_reg[wr_addr] <= wide_w[WEIGHT_BITS-1:0];
        end
        if (cmd.rlx_rd)
        begin
            rd_w_reg <= edge_mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_vld_reg <= '0;
            rd_v_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.take && opcode == srp_pkg::OP_EDGE && a_ok && b_ok)
            begin
                edge_vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rlx_rd)
            begin
                rd_v_reg <= edge_vld_reg[rd_addr];
            end
        end
    end

    // Station positions.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                px_reg[i] <= '0;
                py_reg[i] <= '0;
            end
        end
        else if (cmd.take && opcode == srp_pkg::OP_POS && a_ok)
        begin
            px_reg[a_idx] <= wide_x[CW-1:0];
            py_reg[a_idx] <= wide_y[CW-1:0];
        end
    end

    // Query capture and nearest-station scan.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            qx_reg   <= wide_x[CW-1:0];
            qy_reg   <= wide_y[CW-1:0];
            goal_reg <= goal_node;
        end
        if (cmd.near_sq)
        begin
            sqx_reg <= SQW'(mx * mx);
            sqy_reg <= SQW'(my * my);
        end
        if (cmd.near_cmp && (j_reg == '0 || sq_sum < bsq_reg))
        begin
            bsq_reg   <= sq_sum;
            start_reg <= j_reg;
        end
    end

    // Shared node counter for scan, selection and relaxation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg <= '0;
        end
        else if (cmd.take)
        begin
            j_reg <= '0;
        end
        else if (cmd.near_cmp || cmd.sel_step || cmd.rlx_upd)
        begin
            j_reg <= j_last ? '0 : j_reg + IW'(1);
        end
    end

    // Distances, visited marks and the selection of the next node to settle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                dist_reg[i] <= INF;
            end
            vis_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init)
            begin
                for (int i = 0; i < NODES; i++)
                begin
                    dist_reg[i] <= (IW'(i) == start_reg) ? '0 : INF;
                end
                vis_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.sel_step && !vis_reg[j_reg] && d_rd != INF
                && (!found_reg || d_rd < min_reg))
            begin
                found_reg <= 1'b1;
            end
            if (cmd.settle)
            begin
                vis_reg[u_reg] <= 1'b1;
                found_reg      <= 1'b0;
            end
            if (cmd.rlx_upd && !vis_reg[j_reg] && w_eff != '0 && sum_sat < d_rd)
            begin
                dist_reg[j_reg] <= sum_sat;
            end
        end
    end

    // Payload of the selection and predecessor links.
    always_ff @(posedge clk)
    begin
        if (cmd.sel_step && !vis_reg[j_reg] && d_rd != INF
            && (!found_reg || d_rd < min_reg))
        begin
            min_reg <= d_rd;
            u_reg   <= j_reg;
        end
        if (cmd.settle)
        begin
            udist_reg <= min_reg;
        end
        if (cmd.init)
        begin
            pred_reg[start_reg] <= start_reg;
        end
        if (cmd.rlx_upd && !vis_reg[j_reg] && w_eff != '0 && sum_sat < d_rd)
        begin
            pred_reg[j_reg] <= u_reg;
        end
    end

    // Route trail, walked back from the goal, then read out in reverse.
    always_ff @(posedge clk)
    begin
        if (cmd.trace_init)
        begin
            v_reg <= g_idx;
            n_reg <= '0;
        end
        if (cmd.trace_step)
        begin
            trail_reg[n_reg] <= v_reg;
            if (trace_end)
            begin
                e_reg <= n_reg;
            end
            else
            begin
                v_reg <= pred_reg[v_reg];
                n_reg <= n_reg + IW'(1);
            end
        end
        if (cmd.emit_trail)
        begin
            e_reg <= e_reg - IW'(1);
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_trail || cmd.emit_start)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_trail)
        begin
            node_out_reg <= trail_ext[NB-1:0];
            last_reg     <= e_reg == '0;
            unr_reg      <= 1'b0;
        end
        else if (cmd.emit_start)
        begin
            node_out_reg <= start_ext[NB-1:0];
            last_reg     <= 1'b1;
            unr_reg      <= cmd.out_unr;
        end
    end

    assign out_valid     = out_valid_reg;
    assign route_node    = node_out_reg;
    assign last_in_route = last_reg;
    assign unreachable   = unr_reg;

endmodule

// ----- design/srp_checker.sv -----
// Port-level checks of the station route planner, bound to the top level.
// Depends on srp_pkg and station_route_planner_defines.svh.
`include "station_route_planner_defines.svh"

module srp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [srp_pkg::OP_BITS-1:0]    opcode,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic                           unreachable,
    input logic                           last_in_route
);

    // A stalled item stays offered.
    `SRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // A plan item keeps the block busy in the following cycle.
    `SRP_ASSERT_NEXT(a_plan_busy, in_valid && !in_stall && opcode == srp_pkg::OP_PLAN,
        in_stall)

    // Table writes and unused codes leave the block ready again in the following cycle.
    `SRP_ASSERT_NEXT(a_write_fast, in_valid && !in_stall && opcode != srp_pkg::OP_PLAN,
        !in_stall)

    // An unreachable report is always a single, final item.
    `SRP_ASSERT_NOW(a_unr_last, out_valid && unreachable, last_in_route)

endmodule

bind station_route_planner srp_checker u_srp_checker (.*);

// ----- sim/station_route_checker.sv -----
// Checker for the station route planner: watches both channels, predicts the
// route items of every plan item and compares them with what the block emits.
// Depends on srp_pkg for the opcode constants and field widths.
module station_route_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [srp_pkg::OP_BITS-1:0]       opcode,
    input  logic [srp_pkg::NODE_BITS-1:0]     node_a,
    input  logic [srp_pkg::NODE_BITS-1:0]     node_b,
    input  logic [15:0]                       weight,
    input  logic signed [15:0]                pos_x,
    input  logic signed [15:0]                pos_y,
    input  logic [srp_pkg::NODE_BITS-1:0]     goal_node,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [srp_pkg::NODE_BITS-1:0]     route_node,
    input  logic                              last_in_route,
    input  logic                              unreachable,
    output int                                fail_count,
    output int                                pending_count,
    output int                                route_count
);
    import srp_pkg::*;

    localparam int N = 8;
    localparam logic [19:0] DIST_INF = 20'hFFFFF;

    typedef struct packed {
        logic [NODE_BITS-1:0] node;
        logic                 last;
        logic                 unr;
    } hop_t;

    logic [15:0]        edge_len [N*N];
    logic signed [15:0] stn_x [N];
    logic signed [15:0] stn_y [N];
    hop_t               route_q [$];

    // Works out the route items of one plan item and queues them.
    task automatic plan_route(input logic signed [15:0] cx, input logic signed [15:0] cy,
                              input logic [NODE_BITS-1:0] goal);
        logic [33:0] best_sq;
        logic [33:0] d;
        logic [16:0] dx;
        logic [16:0] dy;
        int          start;
        logic [19:0] node_dist [N];
        bit          done [N];
        int          pred [N];
        int          u;
        logic [20:0] sum;
        int          trail [$];
        int          v;
        hop_t        h;
        start = 0;
        best_sq = '1;
        for (int i = 0; i < N; i++)
        begin
            dx = (cx > stn_x[i]) ? 17'(cx - stn_x[i]) : 17'(stn_x[i] - cx);
            dy = (cy > stn_y[i]) ? 17'(cy - stn_y[i]) : 17'(stn_y[i] - cy);
            d = 34'(dx) * 34'(dx) + 34'(dy) * 34'(dy);
            if (i == 0 || d < best_sq)
            begin
                best_sq = d;
                start = i;
            end
        end
        if (int'(goal) == start)
        begin
            h = '{NODE_BITS'(start), 1'b1, 1'b0};
            route_q.push_back(h);
            return;
        end
        for (int i = 0; i < N; i++)
        begin
            node_dist[i] = DIST_INF;
            done[i] = 0;
            pred[i] = 0;
        end
        node_dist[start] = 0;
        pred[start] = start;
        for (int k = 0; k < N; k++)
        begin
            u = -1;
            for (int j = 0; j < N; j++)
                if (!done[j] && node_dist[j] != DIST_INF
                    && (u < 0 || node_dist[j] < node_dist[u]))
                    u = j;
            if (u < 0)
                break;
            done[u] = 1;
            for (int j = 0; j < N; j++)
            begin
                if (done[j] || edge_len[u*N+j] == 0)
                    continue;
                sum = 21'(node_dist[u]) + 21'(edge_len[u*N+j]);
                if (sum > 21'(DIST_INF - 1))
                    sum = 21'(DIST_INF - 1);
                if (sum[19:0] < node_dist[j])
                begin
                    node_dist[j] = sum[19:0];
                    pred[j] = u;
                end
            end
        end
        if (node_dist[goal] == DIST_INF)
        begin
            h = '{NODE_BITS'(start), 1'b1, 1'b1};
            route_q.push_back(h);
            return;
        end
        v = goal;
        while (trail.size() < N)
        begin
            trail.push_front(v);
            if (v == start)
                break;
            v = pred[v];
        end
        foreach (trail[i])
        begin
            h = '{NODE_BITS'(trail[i]), i == trail.size() - 1, 1'b0};
            route_q.push_back(h);
        end
    endtask

    assign pending_count = route_q.size();

    // Track table writes, predict plans and compare emitted route items.
    always @(posedge clk or negedge rst_n)
    begin
        hop_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < N*N; i++)
                edge_len[i] = '0;
            for (int i = 0; i < N; i++)
            begin
                stn_x[i] = '0;
                stn_y[i] = '0;
            end
            route_q.delete();
            fail_count = 0;
            route_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                route_count++;
                if (route_q.size() == 0)
                begin
                    $error("route item node %0d with nothing expected", route_node);
                    fail_count++;
                end
                else
                begin
                    want = route_q.pop_front();
                    if (route_node !== want.node)
                    begin
                        $error("route_node expected %0d actual %0d", want.node, route_node);
                        fail_count++;
                    end
                    if (last_in_route !== want.last)
                    begin
                        $error("last_in_route expected %0d actual %0d", want.last,
                               last_in_route);
                        fail_count++;
                    end
                    if (unreachable !== want.unr)
                    begin
                        $error("unreachable expected %0d actual %0d", want.unr, unreachable);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                case (opcode)
                    OP_EDGE: edge_len[node_a*N+node_b] = weight;
                    OP_POS:
                    begin
                        stn_x[node_a] = pos_x;
                        stn_y[node_a] = pos_y;
                    end
                    OP_PLAN: plan_route(pos_x, pos_y, goal_node);
                    default: ;
                endcase
            end
        end
    end
endmodule

// ----- sim/tb_station_route_planner.sv -----
// Testbench top of the station route planner: clock, reset, stimulus, verdict.
// Depends on srp_pkg, station_route_planner and station_route_checker.
module tb_station_route_planner;
    import srp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 in_valid = 0;
    logic                 in_stall;
    logic [OP_BITS-1:0]   opcode = '0;
    logic [NODE_BITS-1:0] node_a = '0;
    logic [NODE_BITS-1:0] node_b = '0;
    logic [15:0]          weight = '0;
    logic signed [15:0]   pos_x = '0;
    logic signed [15:0]   pos_y = '0;
    logic [NODE_BITS-1:0] goal_node = '0;
    logic                 out_valid;
    logic                 out_stall = 0;
    logic [NODE_BITS-1:0] route_node;
    logic                 last_in_route;
    logic                 unreachable;
    int                   fail_count;
    int                   pending_count;
    int                   route_count;
    int                   cycle_count = 0;
    int                   item_count = 0;
    int                   plan_count = 0;

    station_route_planner DUT (.*);
    station_route_checker u_checker (.*);

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    // Receiver stalls in a pattern that rotates through three modes.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        case ((cycle_count / 300) % 3)
            0: out_stall <= 0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Present one item and hold it until it is taken.
    task automatic send_item(input logic [OP_BITS-1:0] op, input int a, input int b,
                             input logic [15:0] w, input logic [15:0] x,
                             input logic [15:0] y, input int g);
        opcode <= op;
        node_a <= NODE_BITS'(a);
        node_b <= NODE_BITS'(b);
        weight <= w;
        pos_x <= x;
        pos_y <= y;
        goal_node <= NODE_BITS'(g);
        in_valid <= 1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        item_count++;
        if (op == OP_PLAN)
            plan_count++;
    endtask

    task automatic idle_cycles(input int n);
        in_valid <= 0;
        repeat (n) @(posedge clk);
    endtask

    // One random item, mostly table writes and plans with real content.
    task automatic send_random;
        int pick;
        logic [15:0] w;
        pick = $urandom_range(0, 9);
        w = ($urandom_range(0, 3) == 0) ? 16'(0) :
            ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2000));
        if (pick < 4)
            send_item(OP_EDGE, $urandom_range(0, 7), $urandom_range(0, 7), w, 16'($urandom),
                      16'($urandom), $urandom_range(0, 7));
        else if (pick < 6)
            send_item(OP_POS, $urandom_range(0, 7), $urandom_range(0, 7), 16'($urandom),
                      ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 64))),
                      ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 64))),
                      $urandom_range(0, 7));
        else if (pick < 9)
            send_item(OP_PLAN, $urandom_range(0, 7), $urandom_range(0, 7), 16'($urandom),
                      ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 64))),
                      ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 64))),
                      $urandom_range(0, 7));
        else
            send_item(2'd3, $urandom_range(0, 7), $urandom_range(0, 7), 16'($urandom),
                      16'($urandom), 16'($urandom), $urandom_range(0, 7));
    endtask

    initial
    begin
        int burst;
        int settle;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: plan on empty tables, a chain, ties, extremes, unused opcode.
        send_item(OP_PLAN, 0, 0, 0, 16'h0000, 16'h0000, 0);
        send_item(OP_PLAN, 0, 0, 0, 16'h7FFF, 16'h8000, 5);
        for (int i = 0; i < 8; i++)
            send_item(OP_POS, i, 0, 0, 16'(i * 256), 16'(-i * 256), 0);
        send_item(OP_EDGE, 0, 1, 16'hFFFF, 0, 0, 0);
        send_item(OP_EDGE, 1, 2, 16'hFFFF, 0, 0, 0);
        send_item(OP_EDGE, 2, 3, 16'hFFFF, 0, 0, 0);
        send_item(OP_EDGE, 0, 3, 16'd1, 0, 0, 0);
        send_item(OP_EDGE, 0, 3, 16'd0, 0, 0, 0);
        send_item(OP_EDGE, 7, 7, 16'd5, 0, 0, 0);
        send_item(OP_PLAN, 7, 7, 16'hFFFF, 16'h0000, 16'h0000, 3);
        send_item(OP_PLAN, 0, 0, 0, 16'h0080, 16'hFF80, 7);
        send_item(2'd3, 7, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7);
        send_item(OP_PLAN, 0, 0, 0, 16'h8000, 16'h7FFF, 2);
        send_item(OP_PLAN, 0, 0, 0, 16'h0700, 16'hF900, 7);

        // Wait with the sender quiet until every route item has come.
        in_valid <= 0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);

        // Random bursts with gaps; full drains while the item count lies between 110 and 125.
        while (item_count < 200 || plan_count < 50)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
                send_random();
            if ($urandom_range(0, 2) == 0)
                idle_cycles($urandom_range(1, 40));
            if (item_count > 110 && item_count < 125)
            begin
                in_valid <= 0;
                @(posedge clk);
                while (pending_count != 0)
                    @(posedge clk);
            end
        end
        in_valid <= 0;

        while (pending_count != 0)
            @(posedge clk);
        settle = 0;
        while (settle < 400)
        begin
            @(posedge clk);
            settle++;
        end
        $display("sent %0d items including %0d plans; checked %0d route items",
                 item_count, plan_count, route_count);
        if (fail_count == 0 && pending_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+design
design/srp_pkg.sv
design/srp_ctrl.sv
design/srp_dp.sv
design/station_route_planner.sv
design/srp_checker.sv
sim/station_route_checker.sv
sim/tb_station_route_planner.sv
